// ===== design/mvts_pkg.sv =====
// Package: types, sizes and codes shared by the min-run-time scheduler files.
package mvts_pkg;

	localparam int CAPACITY = 64;
	localparam int CNT_W    = $clog2(CAPACITY + 1);
	localparam int TIME_W   = 32;
	localparam int ID_W     = 16;
	localparam int QUANT_W  = 16;
	localparam int OCC_W    = 7;

	// request codes
	localparam logic REQ_ADD = 1'b0;
	localparam logic REQ_RUN = 1'b1;

	// cell operation codes
	localparam logic [1:0] OP_HOLD = 2'd0;
	localparam logic [1:0] OP_ADD  = 2'd1;
	localparam logic [1:0] OP_RUN  = 2'd2;

	typedef struct packed {
		logic               req_type;
		logic [ID_W-1:0]    task_id;
		logic [TIME_W-1:0]  start_time;
		logic [QUANT_W-1:0] quantum;
	} req_t;

	typedef struct packed {
		logic              ok;
		logic [ID_W-1:0]   chosen_id;
		logic [TIME_W-1:0] old_time;
		logic [TIME_W-1:0] new_time;
		logic [OCC_W-1:0]  occupancy;
	} rsp_t;

	typedef struct packed {
		logic [TIME_W-1:0] vtime;
		logic [ID_W-1:0]   id;
	} entry_t;

	// count reported modulo 128
	function automatic logic [OCC_W-1:0] occ_of(input logic [CNT_W-1:0] cnt);
		logic [31:0] w;
		w = 32'(cnt);
		return w[OCC_W-1:0];
	endfunction

endpackage

// ===== design/min_vruntime_task_scheduler_top.sv =====
// Top level of the min-run-time task scheduler: control, cell row and result register.
//
//  channel | handshake            | dir | payload
//  --------+----------------------+-----+----------------------------------------------------
//  request | req_valid, req_ready | in  | req: req_type, task_id, start_time, quantum
//  result  | rsp_valid, rsp_ready | out | rsp: ok, chosen_id, old_time, new_time, occupancy
//
// An add, and a run on an empty row, finish at the accepting edge, which registers
// the result; the next item can follow at once. A run registers the saturated head
// time at the accepting edge, then shifts the whole cell row once the result
// register is free (drop head + ordered reinsert, all cells compare in parallel).
// Reset clears the task count and control; cell contents are left as they are.
// A full result register stalls: no item is taken and a pending run waits.
module min_vruntime_task_scheduler_top (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           req_valid,
	output logic           req_ready,
	input  mvts_pkg::req_t req,
	output logic           rsp_valid,
	input  logic           rsp_ready,
	output mvts_pkg::rsp_t rsp
);
	import mvts_pkg::*;

	localparam logic ST_IDLE = 1'b0;
	localparam logic ST_RUN  = 1'b1;

	logic              state_q;
	logic [CNT_W-1:0]  count_q;
	logic              rsp_valid_q;
	rsp_t              rsp_q;

	// run in flight
	logic [TIME_W-1:0] nt_q;
	logic [TIME_W-1:0] old_q;
	logic [ID_W-1:0]   id_q;

	logic              req_fire;
	logic              slot_free;
	logic              is_full;
	logic              is_empty;
	logic [TIME_W:0]   sum;
	logic [TIME_W-1:0] sat_sum;
	logic              run_commit;

	logic [1:0]        cell_op;
	logic [TIME_W-1:0] key;
	entry_t            new_entry;

	entry_t            cell_entry [CAPACITY];
	logic [CAPACITY:0] cell_gt;     // extra top bit: beyond the row counts as greater
	logic [CAPACITY-1:0] occupied;

	assign slot_free  = !rsp_valid_q || rsp_ready;
	assign req_ready  = (state_q == ST_IDLE) && slot_free;
	assign req_fire   = req_valid && req_ready;
	assign is_full    = (count_q == CNT_W'(CAPACITY));
	assign is_empty   = (count_q == '0);
	assign run_commit = (state_q == ST_RUN) && slot_free;

	// head time plus quantum, saturating
	assign sum     = {1'b0, cell_entry[0].vtime} + (TIME_W+1)'(req.quantum);
	assign sat_sum = sum[TIME_W] ? {TIME_W{1'b1}} : sum[TIME_W-1:0];

	// what the cell row does this cycle
	always_comb begin
		cell_op   = OP_HOLD;
		key       = req.start_time;
		new_entry = '{vtime: req.start_time, id: req.task_id};
		if (state_q == ST_RUN) begin
			key       = nt_q;
			new_entry = '{vtime: nt_q, id: id_q};
			if (run_commit) begin
				cell_op = OP_RUN;
			end
		end else if (req_fire && req.req_type == REQ_ADD && !is_full) begin
			cell_op = OP_ADD;
		end
	end

	assign cell_gt[CAPACITY] = 1'b1;

	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		entry_t left_e;
		entry_t right_e;
		logic   left_g;

		assign occupied[i] = (32'(count_q) > i);

		if (i == 0) begin : g_first
			assign left_e = new_entry;
			assign left_g = 1'b0;
		end else begin : g_mid
			assign left_e = cell_entry[i-1];
			assign left_g = cell_gt[i-1];
		end

		if (i == CAPACITY - 1) begin : g_last
			assign right_e = new_entry;
		end else begin : g_inner
			assign right_e = cell_entry[i+1];
		end

		mvts_cell u_cell (
			.clk       (clk),
			.op        (cell_op),
			.key       (key),
			.new_entry (new_entry),
			.left      (left_e),
			.right     (right_e),
			.left_gt   (left_g),
			.right_gt  (cell_gt[i+1]),
			.occupied  (occupied[i]),
			.head      (i == 0),
			.entry     (cell_entry[i]),
			.gt        (cell_gt[i])
		);
	end

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			count_q     <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (rsp_valid_q && rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (req_fire) begin
						if (req.req_type == REQ_RUN && !is_empty) begin
							state_q <= ST_RUN;
						end else begin
							rsp_valid_q <= 1'b1;
							if (req.req_type == REQ_ADD && !is_full) begin
								count_q <= count_q + CNT_W'(1);
							end
						end
					end
				end
				ST_RUN: begin
					if (run_commit) begin
						rsp_valid_q <= 1'b1;
						state_q     <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && req_fire) begin
			if (req.req_type == REQ_RUN) begin
				nt_q  <= sat_sum;
				old_q <= cell_entry[0].vtime;
				id_q  <= cell_entry[0].id;
				if (is_empty) begin
					rsp_q <= '{ok: 1'b0, chosen_id: '0, old_time: '0, new_time: '0,
						occupancy: occ_of(count_q)};
				end
			end else if (is_full) begin
				rsp_q <= '{ok: 1'b0, chosen_id: '0, old_time: '0, new_time: '0,
					occupancy: occ_of(count_q)};
			end else begin
				rsp_q <= '{ok: 1'b1, chosen_id: '0, old_time: '0, new_time: '0,
					occupancy: occ_of(count_q + CNT_W'(1))};
			end
		end else if (run_commit) begin
			rsp_q <= '{ok: 1'b1, chosen_id: id_q, old_time: old_q, new_time: nt_q,
				occupancy: occ_of(count_q)};
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	// checks
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(CAPACITY))
		else $error("task count above capacity");

	a_run_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_RUN |-> count_q != '0)
		else $error("run in flight on an empty row");

	a_add_result: assert property (@(posedge clk) disable iff (!arst_n)
		req_fire && req.req_type == REQ_ADD |=> rsp_valid)
		else $error("add gave no result in the next cycle");

	a_time_grows: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> rsp.new_time >= rsp.old_time)
		else $error("run time went down");

	a_run_commit_count: assert property (@(posedge clk) disable iff (!arst_n)
		run_commit |=> $stable(count_q))
		else $error("run changed the task count");

endmodule

// ===== design/mvts_cell.sv =====
// One slot of the sorted task row: holds an entry and moves it left or right.
module mvts_cell (
	input  logic                        clk,
	input  logic [1:0]                  op,
	input  logic [mvts_pkg::TIME_W-1:0] key,
	input  mvts_pkg::entry_t            new_entry,
	input  mvts_pkg::entry_t            left,
	input  mvts_pkg::entry_t            right,
	input  logic                        left_gt,
	input  logic                        right_gt,
	input  logic                        occupied,
	input  logic                        head,
	output mvts_pkg::entry_t            entry,
	output logic                        gt
);
	import mvts_pkg::*;

	entry_t entry_q;
	entry_t entry_d;
	logic   run_left;

	// empty slots rank after everything
	assign gt = !occupied || (entry_q.vtime > key);
	assign entry = entry_q;

	// on a run the row shifts left by one; the slot to our left after the
	// shift is ourselves, except at the head which is being removed
	assign run_left = head ? 1'b0 : gt;

	always_comb begin
		entry_d = entry_q;
		case (op)
			OP_ADD: begin
				if (gt && left_gt) begin
					entry_d = left;
				end else if (gt) begin
					entry_d = new_entry;
				end
			end
			OP_RUN: begin
				if (right_gt && run_left) begin
					entry_d = entry_q;
				end else if (right_gt) begin
					entry_d = new_entry;
				end else begin
					entry_d = right;
				end
			end
			default: begin
				entry_d = entry_q;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		entry_q <= entry_d;
	end

endmodule

// ===== verif/tb.sv =====
// Testbench for the min-run-time task scheduler: predictor, stimulus and result checks.
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	import mvts_pkg::*;

	// Worst case is about 2100 items, with the longest sender gaps and receiver stalls;
	// the limit leaves a wide margin over that.
	localparam int CYCLE_LIMIT = 800000;
	localparam int LONG_HOLD   = 300;   // receiver hold-off that backs up the block
	localparam int TAIL_CYCLES = 8;     // quiet cycles after the last result
	localparam int RANDOM_ITEMS = 1900;

	typedef enum int {
		READY_ALWAYS,
		READY_MOSTLY,
		READY_RARELY,
		READY_NEVER
	} ready_mode_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic req_valid = 1'b0;
	logic req_ready;
	req_t req = '0;
	logic rsp_valid;
	logic rsp_ready = 1'b0;
	rsp_t rsp;

	min_vruntime_task_scheduler_top i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp       (rsp)
	);

	always #1 clk = ~clk;

	// ------------------------------------------------------------------
	// Scheduler predictor: its own sorted store, ascending run time,
	// earlier entry first among equal times.
	// ------------------------------------------------------------------
	logic [TIME_W-1:0] sched_time [CAPACITY];
	logic [ID_W-1:0]   sched_id   [CAPACITY];
	int                sched_count = 0;
	int                peak_count = 0;

	// outcomes still to come out of the block, oldest first
	rsp_t due_results [$];

	int err_cnt = 0;
	int n_sent = 0;
	int n_checked = 0;
	int n_full_rejects = 0;
	int n_empty_runs = 0;
	int n_saturated = 0;

	// Insert behind every entry whose time is <= t; room is guaranteed by the caller.
	function automatic void sched_place(input logic [ID_W-1:0] id, input logic [TIME_W-1:0] t);
		int pos;
		pos = sched_count;
		while (pos > 0 && sched_time[pos-1] > t) begin
			sched_time[pos] = sched_time[pos-1];
			sched_id[pos]   = sched_id[pos-1];
			pos--;
		end
		sched_time[pos] = t;
		sched_id[pos]   = id;
		sched_count++;
		if (sched_count > peak_count)
			peak_count = sched_count;
	endfunction

	// Apply one request to the predicted store and return the result it should give.
	function automatic rsp_t schedule_outcome(input req_t r);
		rsp_t              res;
		logic [ID_W-1:0]   hid;
		logic [TIME_W-1:0] ht;
		logic [TIME_W-1:0] nt;
		logic [TIME_W:0]   sum;
		res = '0;
		if (r.req_type == REQ_ADD) begin
			if (sched_count < CAPACITY) begin
				sched_place(r.task_id, r.start_time);
				res.ok = 1'b1;
			end else begin
				n_full_rejects++;
			end
		end else if (sched_count > 0) begin
			hid = sched_id[0];
			ht  = sched_time[0];
			sum = {1'b0, ht} + {{(TIME_W + 1 - QUANT_W){1'b0}}, r.quantum};
			if (sum[TIME_W]) begin
				nt = '1;
				n_saturated++;
			end else begin
				nt = sum[TIME_W-1:0];
			end
			// drop the head, then put it back in order
			for (int i = 1; i < sched_count; i++) begin
				sched_time[i-1] = sched_time[i];
				sched_id[i-1]   = sched_id[i];
			end
			sched_count--;
			sched_place(hid, nt);
			res.ok        = 1'b1;
			res.chosen_id = hid;
			res.old_time  = ht;
			res.new_time  = nt;
		end else begin
			n_empty_runs++;
		end
		res.occupancy = OCC_W'(sched_count);
		return res;
	endfunction

	// ------------------------------------------------------------------
	// Result side: compare against the oldest outstanding outcome.
	// ------------------------------------------------------------------
	task automatic check_result(input rsp_t got);
		rsp_t want;
		if (due_results.size() == 0) begin
			$error("result with nothing outstanding: ok=%0d id=%h occ=%0d",
				got.ok, got.chosen_id, got.occupancy);
			err_cnt++;
		end else begin
			want = due_results.pop_front();
			n_checked++;
			if (got.ok !== want.ok) begin
				$error("ok: expected %0d, got %0d", want.ok, got.ok);
				err_cnt++;
			end
			if (got.chosen_id !== want.chosen_id) begin
				$error("chosen_id: expected %h, got %h", want.chosen_id, got.chosen_id);
				err_cnt++;
			end
			if (got.old_time !== want.old_time) begin
				$error("old_time: expected %h, got %h", want.old_time, got.old_time);
				err_cnt++;
			end
			if (got.new_time !== want.new_time) begin
				$error("new_time: expected %h, got %h", want.new_time, got.new_time);
				err_cnt++;
			end
			if (got.occupancy !== want.occupancy) begin
				$error("occupancy: expected %0d, got %0d", want.occupancy, got.occupancy);
				err_cnt++;
			end
		end
	endtask

	// Receiver: checks at the edge, then picks the next ready value. A long
	// hold-off, requested by a test, overrides the random pattern.
	bit          hold_request = 1'b0;
	int          hold_cnt = 0;
	ready_mode_t pat_mode = READY_ALWAYS;
	int          pat_left = 0;

	always @(posedge clk) begin
		if (arst_n && rsp_valid && rsp_ready)
			check_result(rsp);
		if (hold_request) begin
			hold_request = 1'b0;
			hold_cnt = LONG_HOLD;
		end
		if (hold_cnt > 0) begin
			hold_cnt--;
			rsp_ready <= 1'b0;
		end else begin
			if (pat_left == 0) begin
				pat_mode = ready_mode_t'($urandom_range(0, 3));
				pat_left = $urandom_range(1, 64);
			end
			pat_left--;
			case (pat_mode)
				READY_ALWAYS: rsp_ready <= 1'b1;
				READY_MOSTLY: rsp_ready <= ($urandom_range(0, 3) != 0);
				READY_RARELY: rsp_ready <= ($urandom_range(0, 3) == 0);
				default:      rsp_ready <= 1'b0;
			endcase
		end
	end

	// Watchdog.
	int cycles = 0;
	always @(posedge clk) begin
		cycles++;
		if (cycles >= CYCLE_LIMIT) begin
			$error("no progress after %0d cycles, %0d results outstanding",
				cycles, due_results.size());
			$display("simulation failed");
			$finish;
		end
	end

	// ------------------------------------------------------------------
	// Request side.
	// ------------------------------------------------------------------
	int burst_left = 0;

	// Offer one item, with a random gap at the start of each burst; returns at the
	// accepting edge, after the outcome has been predicted.
	task automatic send_item(input req_t r);
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 40);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
			if (gap > 0) begin
				req_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		req       <= r;
		req_valid <= 1'b1;
		@(posedge clk);
		while (!req_ready)
			@(posedge clk);
		due_results.push_back(schedule_outcome(r));
		n_sent++;
	endtask

	function automatic req_t make_req(input logic kind, input logic [ID_W-1:0] id,
			input logic [TIME_W-1:0] t, input logic [QUANT_W-1:0] q);
		req_t r;
		r.req_type   = kind;
		r.task_id    = id;
		r.start_time = t;
		r.quantum    = q;
		return r;
	endfunction

	// Times cluster low so ties are common, with some full-range and near-max values.
	function automatic logic [TIME_W-1:0] pick_time();
		case ($urandom_range(0, 3))
			0:       return TIME_W'($urandom_range(0, 31));
			1:       return TIME_W'($urandom);
			2:       return 32'hFFFF_FFFF - TIME_W'($urandom_range(0, 300));
			default: return TIME_W'($urandom_range(0, 4096));
		endcase
	endfunction

	function automatic logic [QUANT_W-1:0] pick_quantum();
		case ($urandom_range(0, 4))
			0:       return QUANT_W'($urandom_range(0, 3));
			1:       return QUANT_W'($urandom);
			2:       return '1;
			3:       return '0;
			default: return QUANT_W'($urandom_range(0, 64));
		endcase
	endfunction

	// Random item; the fields a request ignores still carry random values.
	function automatic req_t random_req(input bit is_add);
		return make_req(is_add ? REQ_ADD : REQ_RUN, ID_W'($urandom), pick_time(),
			pick_quantum());
	endfunction

	// Sender pause: nothing offered until every outstanding result is back.
	task automatic wait_all_results();
		req_valid <= 1'b0;
		while (due_results.size() != 0)
			@(posedge clk);
		@(posedge clk);
		burst_left = 0;
	endtask

	// ------------------------------------------------------------------
	// Tests.
	// ------------------------------------------------------------------

	// A run with nothing stored is rejected and reports zero fields.
	task automatic test_run_empty();
		send_item(make_req(REQ_RUN, 16'hFFFF, 32'hFFFF_FFFF, 16'hFFFF));
		send_item(make_req(REQ_RUN, 16'h0000, 32'h0000_0000, 16'h0000));
	endtask

	// Run time that overflows sticks at the maximum; equal maxima keep entry order.
	task automatic test_saturation();
		send_item(make_req(REQ_ADD, 16'hA5A5, 32'hFFFF_FF00, 16'hFFFF));
		send_item(make_req(REQ_RUN, 16'h1111, 32'h1234_5678, 16'hFFFF));
		send_item(make_req(REQ_RUN, 16'h2222, 32'h0, 16'h0000));
		send_item(make_req(REQ_ADD, 16'h5A5A, 32'hFFFF_FFFF, 16'h0));
		send_item(make_req(REQ_RUN, 16'h0, 32'h0, 16'h0001));
		send_item(make_req(REQ_RUN, 16'h0, 32'h0, 16'h0001));
	endtask

	// Extreme ids and times go in front of the saturated tasks.
	task automatic test_extremes();
		send_item(make_req(REQ_ADD, 16'h0000, 32'h0000_0000, 16'hFFFF));
		send_item(make_req(REQ_ADD, 16'hFFFF, 32'h0000_0001, 16'h0));
		send_item(make_req(REQ_RUN, 16'hFFFF, 32'hFFFF_FFFF, 16'h0000));
		send_item(make_req(REQ_RUN, 16'h0, 32'h0, 16'hFFFF));
		send_item(make_req(REQ_RUN, 16'h0, 32'h0, 16'h8000));
	endtask

	// Equal times: first in first out, and a rerun task lands behind its equals.
	task automatic test_ties();
		send_item(make_req(REQ_ADD, 16'h0101, 32'd7, 16'h0));
		send_item(make_req(REQ_ADD, 16'h0202, 32'd7, 16'h0));
		send_item(make_req(REQ_ADD, 16'h0303, 32'd6, 16'h0));
		send_item(make_req(REQ_RUN, 16'h0, 32'h0, 16'd1));   // 6 -> 7, behind both
		send_item(make_req(REQ_RUN, 16'h0, 32'h0, 16'd0));
		send_item(make_req(REQ_RUN, 16'h0, 32'h0, 16'd0));
		send_item(make_req(REQ_RUN, 16'h0, 32'h0, 16'd0));
	endtask

	// Mostly runs with sparse adds, so the store grows slowly and runs are seen
	// at every occupancy on the way to full.
	task automatic test_random_mix();
		for (int n = 0; n < RANDOM_ITEMS; n++)
			send_item(random_req($urandom_range(0, 27) == 0));
	endtask

	// Receiver holds off for a long stretch while the sender keeps offering.
	task automatic test_backpressure();
		hold_request = 1'b1;
		while (hold_cnt == 0)
			@(posedge clk);
		for (int n = 0; n < 30; n++)
			send_item(random_req($urandom_range(0, 3) == 0));
	endtask

	// Top the store up to capacity, then adds are refused and runs still work.
	task automatic test_full_store();
		while (sched_count < CAPACITY)
			send_item(random_req(1'b1));
		send_item(make_req(REQ_ADD, 16'hFFFF, 32'h0, 16'hFFFF));
		send_item(make_req(REQ_ADD, 16'h0000, 32'hFFFF_FFFF, 16'h0));
		send_item(random_req(1'b1));
		send_item(make_req(REQ_RUN, 16'h0, 32'h0, 16'hFFFF));
		send_item(make_req(REQ_RUN, 16'h0, 32'h0, 16'h0));
		send_item(random_req(1'b0));
		send_item(random_req(1'b1));
	endtask

	initial begin
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_run_empty();
		test_saturation();
		test_extremes();
		test_ties();
		wait_all_results();
		test_random_mix();
		test_backpressure();
		test_full_store();
		wait_all_results();

		repeat (TAIL_CYCLES) @(posedge clk);
		if (due_results.size() != 0) begin
			$error("%0d results never arrived", due_results.size());
			err_cnt++;
		end

		$display("run covered %0d requests, %0d results compared, peak occupancy %0d of %0d",
			n_sent, n_checked, peak_count, CAPACITY);
		$display("refused adds %0d, runs on empty %0d, saturated runs %0d",
			n_full_rejects, n_empty_runs, n_saturated);
		if (err_cnt == 0) begin
			$display("simulation ok");
		end else begin
			$display("simulation failed");
		end
		$finish;
	end

endmodule
